// ----- hdl/utf8_stream_decoder_defines.svh -----
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/u8d_pkg.sv -----
package u8d_pkg;

	localparam int U8D_QUEUE_DEPTH = 4;

	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	// one decoded byte's worth of results: rep_cnt replacements, then an optional tail
	typedef struct packed {
		logic [2:0]  rep_cnt;
		logic        has_tail;
		logic [20:0] tail_cp;
		logic        fin;
	} job_t;

endpackage

// ----- hdl/utf8_stream_decoder.sv -----
// path: an accepted byte's job is written into the job queue, then loaded into the output register
// throughput: one byte per cycle while each byte makes at most one result and cp_ready stays high
// a byte that makes n results holds the output stage until all n are taken; the job queue absorbs bursts
// reset: arst_n clears the sequence state, the job queue and the output valid at once
module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        cp_valid,
	input  logic        cp_ready,
	output logic [20:0] code_point,
	output logic        run_end,
	output logic        text_end
);
	import u8d_pkg::*;

	`include "utf8_stream_decoder_defines.svh"

	// front to queue
	logic job_wr;
	job_t job_in;
	logic q_full;

	// queue to back
	logic q_valid;
	job_t q_job;
	logic q_pop;

	// front: tracks the open sequence and turns each byte transfer that yields results into a job
	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.job_valid  (job_wr),
		.job        (job_in)
	);

	// short job queue so the back can stall on multi-result bytes
	u8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_wr),
		.wr_job   (job_in),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_job   (q_job),
		.rd_pop   (q_pop)
	);

	// back: expands a job into replacement results plus optional tail, one per cycle while cp_ready is high
	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_valid),
		.job        (q_job),
		.job_pop    (q_pop),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.code_point (code_point),
		.run_end    (run_end),
		.text_end   (text_end)
	);

	// only the tail of a job can be a decoded value; earlier results are replacements
	`U8D_ASSERT_NOW(a_mid_is_repl, cp_valid && !run_end, code_point == REPLACEMENT_CP, "non-last result is not U+FFFD")

	// end of text always closes the run of its byte
	`U8D_ASSERT_NOW(a_text_end_run, cp_valid && text_end, run_end, "text_end without run_end")

	// a result only appears after a job sat in the queue
	`U8D_ASSERT_NOW(a_out_from_queue, $rose(cp_valid), $past(q_valid), "output without queued job")

endmodule

// ----- hdl/u8d_front.sv -----
module u8d_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  logic [7:0]    text_byte,
	input  logic          final_byte,
	input  logic          q_full,
	output logic          job_valid,
	output u8d_pkg::job_t job
);
	import u8d_pkg::*;

	logic [1:0]  needed_q;
	logic [1:0]  held_q;
	logic [14:0] partial_q;

	logic [1:0]  nxt_needed;
	logic [1:0]  nxt_held;
	logic [14:0] nxt_part;
	logic        accept;
	logic        cont;
	logic [1:0]  held_inc;
	logic [20:0] full_cp;
	logic        as_lead;
	logic [2:0]  rep;
	logic        has_tail;
	logic [20:0] tail;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;
	assign cont       = (text_byte[7:6] == 2'b10);
	assign held_inc   = held_q + 2'd1;
	assign full_cp    = {partial_q, text_byte[5:0]};

	always_comb begin
		as_lead    = 1'b1;
		rep        = 3'd0;
		has_tail   = 1'b0;
		tail       = REPLACEMENT_CP;
		nxt_needed = needed_q;
		nxt_held   = held_q;
		nxt_part   = partial_q;

		if (needed_q != 2'd0) begin
			if (cont) begin
				as_lead = 1'b0;
				if (held_inc >= needed_q) begin
					has_tail   = 1'b1;
					tail       = full_cp;
					nxt_needed = 2'd0;
					nxt_held   = 2'd0;
					nxt_part   = 15'd0;
				end else if (final_byte) begin
					rep        = {1'b0, held_inc} + 3'd1;
					nxt_needed = 2'd0;
					nxt_held   = 2'd0;
					nxt_part   = 15'd0;
				end else begin
					nxt_held = held_inc;
					nxt_part = full_cp[14:0];
				end
			end else begin
				// broken sequence: flush lead and held continuations
				rep        = {1'b0, held_q} + 3'd1;
				nxt_needed = 2'd0;
				nxt_held   = 2'd0;
				nxt_part   = 15'd0;
			end
		end

		if (as_lead) begin
			case (text_byte) inside
				[8'h00:8'h7F]: begin
					has_tail = 1'b1;
					tail     = {13'd0, text_byte};
				end
				[8'hC0:8'hDF]: begin
					nxt_needed = 2'd1;
					nxt_held   = 2'd0;
					nxt_part   = {10'd0, text_byte[4:0]};
				end
				[8'hE0:8'hEF]: begin
					nxt_needed = 2'd2;
					nxt_held   = 2'd0;
					nxt_part   = {11'd0, text_byte[3:0]};
				end
				[8'hF0:8'hF7]: begin
					nxt_needed = 2'd3;
					nxt_held   = 2'd0;
					nxt_part   = {12'd0, text_byte[2:0]};
				end
				default: begin
					has_tail = 1'b1;
					tail     = REPLACEMENT_CP;
				end
			endcase
			// lead as the last byte of the text
			if (final_byte && nxt_needed != 2'd0) begin
				rep = rep + 3'd1;
			end
		end

		if (final_byte) begin
			nxt_needed = 2'd0;
			nxt_held   = 2'd0;
			nxt_part   = 15'd0;
		end
	end

	assign job_valid    = accept && (rep != 3'd0 || has_tail);
	assign job.rep_cnt  = rep;
	assign job.has_tail = has_tail;
	assign job.tail_cp  = tail;
	assign job.fin      = final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q  <= 2'd0;
			held_q    <= 2'd0;
			partial_q <= 15'd0;
		end else if (accept) begin
			needed_q  <= nxt_needed;
			held_q    <= nxt_held;
			partial_q <= nxt_part;
		end
	end

endmodule

// ----- hdl/u8d_queue.sv -----
module u8d_queue #(
	parameter int DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  u8d_pkg::job_t wr_job,
	output logic          full,
	output logic          rd_valid,
	output u8d_pkg::job_t rd_job,
	input  logic          rd_pop
);
	import u8d_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ----- hdl/u8d_back.sv -----
module u8d_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  u8d_pkg::job_t job,
	output logic          job_pop,
	output logic          cp_valid,
	input  logic          cp_ready,
	output logic [20:0]   code_point,
	output logic          run_end,
	output logic          text_end
);
	import u8d_pkg::*;

	logic [2:0]  idx_q;
	logic        valid_q;
	logic [20:0] cp_q;
	logic        run_end_q;
	logic        text_end_q;

	logic [2:0] total;
	logic       last;
	logic       is_tail;
	logic       load;

	assign total   = job.rep_cnt + {2'd0, job.has_tail};
	assign last    = (idx_q + 3'd1 == total);
	assign is_tail = job.has_tail && (idx_q == job.rep_cnt);
	assign load    = job_valid && (!valid_q || cp_ready);
	assign job_pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 3'd0 : idx_q + 3'd1;
			end else if (cp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q       <= is_tail ? job.tail_cp : REPLACEMENT_CP;
			run_end_q  <= last;
			text_end_q <= last && job.fin;
		end
	end

	assign cp_valid   = valid_q;
	assign code_point = cp_q;
	assign run_end    = run_end_q;
	assign text_end   = text_end_q;

endmodule

// ----- verif/u8d_tb_pkg.sv -----
package u8d_tb_pkg;

	// top bits that classify a byte of the text
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [4:0] STRAY_TAG = 5'b11111;

endpackage

// ----- verif/utf8_decode_checker.sv -----
module utf8_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	input  logic        cp_valid,
	input  logic        cp_ready,
	input  logic [20:0] code_point,
	input  logic        run_end,
	input  logic        text_end,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import u8d_tb_pkg::*;

	typedef struct packed {
		logic [20:0] cp;
		logic        run_end;
		logic        text_end;
	} cp_result_t;

	cp_result_t  decoded_q[$];
	cp_result_t  burst_q[$];
	logic [1:0]  seq_need = '0;
	logic [1:0]  seq_held = '0;
	logic [14:0] seq_acc  = '0;

	function automatic void push_cp(input logic [20:0] cp);
		cp_result_t r;
		r.cp = cp;
		r.run_end = 1'b0;
		r.text_end = 1'b0;
		burst_q.push_back(r);
	endfunction

	function automatic void close_seq();
		seq_need = 2'd0;
		seq_held = 2'd0;
		seq_acc = '0;
	endfunction

	// one replacement for the lead, one per continuation held
	function automatic void flush_seq();
		for (int k = 0; k <= int'(seq_held); k++)
			push_cp(u8d_pkg::REPLACEMENT_CP);
		close_seq();
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic fin);
		cp_result_t  last;
		logic [20:0] full;
		logic        as_lead;
		burst_q.delete();
		as_lead = 1'b1;
		if (seq_need != 2'd0) begin
			if (b[7:6] == CONT_TAG) begin
				full = {seq_acc, b[5:0]};
				as_lead = 1'b0;
				seq_held = seq_held + 2'd1;
				if (seq_held >= seq_need) begin
					push_cp(full);
					close_seq();
				end else if (fin) begin
					flush_seq();
				end else begin
					seq_acc = full[14:0];
				end
			end else begin
				flush_seq();
			end
		end
		if (as_lead) begin
			if (!b[7]) begin
				push_cp({13'd0, b});
			end else if (b[7:5] == LEAD2_TAG) begin
				seq_need = 2'd1;
				seq_held = 2'd0;
				seq_acc = {10'd0, b[4:0]};
			end else if (b[7:4] == LEAD3_TAG) begin
				seq_need = 2'd2;
				seq_held = 2'd0;
				seq_acc = {11'd0, b[3:0]};
			end else if (b[7:3] == LEAD4_TAG) begin
				seq_need = 2'd3;
				seq_held = 2'd0;
				seq_acc = {12'd0, b[2:0]};
			end else begin
				push_cp(u8d_pkg::REPLACEMENT_CP);
			end
			if (fin && seq_need != 2'd0)
				flush_seq();
		end
		if (fin)
			close_seq();
		if (burst_q.size() > 0) begin
			last = burst_q.pop_back();
			last.run_end = 1'b1;
			last.text_end = fin;
			burst_q.push_back(last);
			foreach (burst_q[i])
				decoded_q.push_back(burst_q[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cp_result_t want;
		if (!arst_n) begin
			decoded_q.delete();
			close_seq();
			fail_count = 0;
			pending = 0;
		end else begin
			// results leave only after their byte's job passes the queue and output register, so compare before predicting
			if (cp_valid && cp_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, got cp %h",
						$time, code_point);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					if (code_point !== want.cp) begin
						$display("%0t: code_point expected %h got %h",
							$time, want.cp, code_point);
						fail_count++;
					end
					if (run_end !== want.run_end) begin
						$display("%0t: run_end expected %b got %b",
							$time, want.run_end, run_end);
						fail_count++;
					end
					if (text_end !== want.text_end) begin
						$display("%0t: text_end expected %b got %b",
							$time, want.text_end, text_end);
						fail_count++;
					end
				end
			end
			if (byte_valid && byte_ready)
				predict_byte(text_byte, final_byte);
			pending = decoded_q.size();
		end
	end

endmodule

// ----- verif/utf8_stream_decoder_tb.sv -----
module utf8_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import u8d_tb_pkg::*;

	localparam int IDLE_PCT       = 13;     // chance in a hundred that a side idles
	localparam int RANDOM_ITEMS   = 220;
	localparam int PRESSURE_ITEMS = 30;
	localparam int HOLD_CYCLES    = 90;     // receiver hold-off that backs up the block
	localparam int DRAIN_CYCLES   = 12;     // quiet time after the last result
	localparam int CYCLE_LIMIT    = 100000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  text_byte = '0;
	logic        final_byte = 1'b0;
	logic        cp_valid;
	logic        cp_ready = 1'b0;
	logic [20:0] code_point;
	logic        run_end;
	logic        text_end;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          items_sent = 0;
	logic        steady = 1'b0;     // both sides run without gaps
	logic        hold_req = 1'b0;   // asks the receiver for its one long hold-off
	logic [7:0]  text_q[$];         // bytes of the text being built
	logic [8:0]  directed_q[$];     // final flag in bit 8, byte below

	utf8_stream_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.cp_valid(cp_valid),
		.cp_ready(cp_ready),
		.code_point(code_point),
		.run_end(run_end),
		.text_end(text_end)
	);

	utf8_decode_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.cp_valid(cp_valid),
		.cp_ready(cp_ready),
		.code_point(code_point),
		.run_end(run_end),
		.text_end(text_end),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("utf8_stream_decoder_tb NOT OK");
			$finish;
		end
	end

	// offer one byte at a falling edge, return at the falling edge after its transfer
	// valid stays high into the next byte unless a random gap is taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		text_byte = b;
		final_byte = fin;
		// ready read right at the edge is the value the block sampled
		do @(posedge clk); while (!byte_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// append one piece of text: mostly well-formed, some noise and cut sequences
	task automatic add_token();
		logic [7:0] r;
		int         kind;
		int         conts;
		kind = $urandom_range(99);
		conts = $urandom_range(3, 1);
		if (kind < 40) begin
			r = 8'($urandom);
			text_q.push_back({1'b0, r[6:0]});
		end else if (kind < 75 || kind >= 90) begin
			r = 8'($urandom);
			case (conts)
				1: text_q.push_back({LEAD2_TAG, r[4:0]});
				2: text_q.push_back({LEAD3_TAG, r[3:0]});
				default: text_q.push_back({LEAD4_TAG, r[2:0]});
			endcase
			// a cut sequence keeps fewer continuations than its lead asks for
			if (kind >= 90)
				conts = $urandom_range(conts - 1, 0);
			for (int k = 0; k < conts; k++) begin
				r = 8'($urandom);
				text_q.push_back({CONT_TAG, r[5:0]});
			end
		end else if (kind < 85) begin
			// continuation with no open sequence
			r = 8'($urandom);
			text_q.push_back({CONT_TAG, r[5:0]});
		end else begin
			// 0xf8 and up never start a sequence
			r = 8'($urandom);
			text_q.push_back({STRAY_TAG, r[2:0]});
		end
	endtask

	task automatic build_text(input int min_bytes);
		text_q.delete();
		do add_token(); while (text_q.size() < min_bytes);
	endtask

	// last byte of the text carries the final flag
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	// receiver: random gaps, a gap-free stretch, and one long hold-off
	initial begin
		int   hold_left;
		logic held_once;
		hold_left = 0;
		held_once = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held_once) begin
				hold_left = HOLD_CYCLES;
				held_once = 1'b1;
			end
			if (hold_left > 0) begin
				cp_ready = 1'b0;
				hold_left--;
			end else begin
				cp_ready = steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int start_count;
		directed_q = '{
			9'h000, 9'h07F,                 // ascii extremes
			9'h0C2, 9'h0A9,                 // two-byte sequence
			9'h0E2, 9'h082, 9'h0AC,         // three-byte sequence
			9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, // four-byte, largest value
			9'h080,                         // stray continuation
			9'h0FF,                         // byte that is never valid
			9'h0F0, 9'h09F, 9'h098, 9'h0F8, // broken after two continuations
			9'h0E0, 9'h041,                 // broken by ascii, which still decodes
			9'h1C0,                         // text ends on a lead
			9'h0E2, 9'h182,                 // text ends mid-sequence
			9'h141                          // one-byte text
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed bytes
		foreach (directed_q[i])
			send_byte(directed_q[i][7:0], directed_q[i][8]);

		// backpressure: receiver stops while the sender keeps offering,
		// so the job queue fills and byte_ready drops
		hold_req <= 1'b1;
		build_text(PRESSURE_ITEMS);
		send_text();
		hold_req <= 1'b0;

		// random texts, with a gap-free stretch in the middle
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			steady <= (items_sent - start_count >= 70) && (items_sent - start_count < 130);
			build_text($urandom_range(14, 1));
			send_text();
		end
		steady <= 1'b0;
		byte_valid = 1'b0;

		// let every expected code point arrive, then watch for extras
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("utf8_stream_decoder_tb OK");
		end else begin
			$display("utf8_stream_decoder_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/u8d_pkg.sv
hdl/u8d_front.sv
hdl/u8d_queue.sv
hdl/u8d_back.sv
hdl/utf8_stream_decoder.sv
verif/u8d_tb_pkg.sv
verif/utf8_decode_checker.sv
verif/utf8_stream_decoder_tb.sv
